### design/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define A64EX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define A64EX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/a64ex_pkg.sv
package a64ex_pkg;

  localparam int XLEN     = 64;
  localparam int ILEN     = 32;
  localparam int NREGS    = 32;
  localparam int RIDX_W   = 5;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = 144;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNHANDLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 2'd2;

  localparam logic [5:0] OP_ADDSUB_IMM = 6'b100010;
  localparam logic [4:0] OP_BRANCH     = 5'b00101;

  localparam logic [RIDX_W-1:0] REG_LINK = 5'd30;
  localparam logic [RIDX_W-1:0] REG_SP   = 5'd31;

  localparam logic [XLEN-1:0] MASK32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [XLEN-1:0] PC_STEP = 64'd4;

  typedef struct packed {
    logic              n;
    logic              z;
    logic              c;
    logic              v;
  } flags_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [XLEN-1:0]     next_pc;
    flags_t              flags;
    logic                reg_written;
    logic [RIDX_W-1:0]   reg_index;
    logic [XLEN-1:0]     reg_value;
  } result_t;

endpackage

### design/a64ex_regfile.sv
module a64ex_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [a64ex_pkg::RIDX_W-1:0]  rd_addr,
  output logic [a64ex_pkg::XLEN-1:0]    rd_data,
  input  logic                          wr_en,
  input  logic [a64ex_pkg::RIDX_W-1:0]  wr_addr,
  input  logic [a64ex_pkg::XLEN-1:0]    wr_data
);
  import a64ex_pkg::*;

  logic [XLEN-1:0]  mem [NREGS];
  logic [NREGS-1:0] valid;
  logic [XLEN-1:0]  mem_q;
  logic             vld_q;
  logic             byp_hit;
  logic [XLEN-1:0]  byp_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      byp_val <= wr_data;
    end
  end

  // valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      vld_q   <= 1'b0;
      byp_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q   <= valid[rd_addr];
        byp_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // write in the same cycle as the read is forwarded
  assign rd_data = byp_hit ? byp_val : (vld_q ? mem_q : '0);

endmodule

### design/a64ex_exec.sv
module a64ex_exec (
  input  logic [a64ex_pkg::ILEN-1:0] instr,
  input  logic [a64ex_pkg::XLEN-1:0] rn_data,
  input  logic [a64ex_pkg::XLEN-1:0] pc,
  input  a64ex_pkg::flags_t          flags,
  input  logic                       halted,
  output a64ex_pkg::result_t         res
);
  import a64ex_pkg::*;

  logic            sf;
  logic            sub;
  logic            setf;
  logic [XLEN-1:0] mask;
  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic [XLEN:0]   sum;
  logic [XLEN-1:0] alu;
  logic            carry;
  logic [XLEN-1:0] ovf_vec;
  logic            top_n;
  logic            top_v;
  logic [XLEN-1:0] pc_inc;
  logic [XLEN-1:0] br_off;
  logic [XLEN-1:0] br_target;

  always_comb begin
    sf   = instr[31];
    sub  = instr[30];
    setf = instr[29];
    mask = sf ? '1 : MASK32;
    imm  = instr[22] ? {40'd0, instr[21:10], 12'd0} : {52'd0, instr[21:10]};
    a    = rn_data & mask;
    b    = sub ? (~imm & mask) : imm;
    sum  = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, sub};
    alu  = sum[XLEN-1:0] & mask;
    carry = sf ? sum[XLEN] : sum[32];
    ovf_vec = (a ^ alu) & (b ^ alu);
    top_n = sf ? alu[63] : alu[31];
    top_v = sf ? ovf_vec[63] : ovf_vec[31];
    pc_inc = pc + PC_STEP;
    br_off = {{36{instr[25]}}, instr[25:0], 2'b00};
    br_target = pc + br_off;

    res.status      = ST_OK;
    res.next_pc     = pc;
    res.flags       = flags;
    res.reg_written = 1'b0;
    res.reg_index   = '0;
    res.reg_value   = '0;

    if (halted) begin
      res.status = ST_HALTED;
    end else if (instr[28:23] == OP_ADDSUB_IMM) begin
      res.next_pc = pc_inc;
      if (setf) begin
        res.flags.n = top_n;
        res.flags.z = (alu == '0);
        res.flags.c = carry;
        res.flags.v = top_v;
      end
      // flag-setting write to the stack pointer slot is a compare
      if (!(setf && instr[4:0] == REG_SP)) begin
        res.reg_written = 1'b1;
        res.reg_index   = instr[4:0];
        res.reg_value   = alu;
      end
    end else if (instr[30:26] == OP_BRANCH) begin
      res.next_pc = br_target;
      if (instr[31]) begin
        res.reg_written = 1'b1;
        res.reg_index   = REG_LINK;
        res.reg_value   = pc_inc;
      end
    end else begin
      res.status = ST_UNHANDLED;
    end
  end

endmodule

### design/aarch64_addsub_imm_branch_executor.sv
// AArch64 ADD/SUB/ADDS/SUBS immediate and B/BL executor.
// s_* carries one 32-bit instruction word per transfer; m_* returns one
// result per instruction: m_tuser is the status (executed, unhandled,
// halted), m_tdata the next pc, NZCV and the register write.
// cfg_wr_en with cfg_wr_data loads the program counter; write only while
// the block holds no instruction.
// The general registers live in a 32x64 synchronous RAM read when the
// instruction is accepted into the execute register; the combinational
// execute result then lands in the output register, which drives m_tvalid
// and holds the result until it transfers.
// A write-back in the cycle of a dependent read is forwarded, so one
// instruction per cycle is sustained while m_tready stays high.
// Reset clears the registers (through per-entry valid bits), flags, halt
// and pc (to zero).
// When the receiver stalls, one result waits at the output and one
// instruction in execute; then s_tready drops.
// After an unhandled encoding every further instruction returns halted.
module aarch64_addsub_imm_branch_executor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [a64ex_pkg::XLEN-1:0]    cfg_wr_data,    // start_address
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [a64ex_pkg::ILEN-1:0]    s_tdata,        // instruction
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // next_pc, flag_n, flag_z, flag_c, flag_v, reg_written, reg_index, reg_value, pad
  output logic [a64ex_pkg::TDATA_W-1:0] m_tdata,
  output logic [a64ex_pkg::STATUS_W-1:0] m_tuser        // status
);
  import a64ex_pkg::*;

  logic            ex_valid;
  logic [ILEN-1:0] ex_instr;
  logic            advance;
  logic            accept;
  logic [XLEN-1:0] rn_data;
  logic [XLEN-1:0] pc;
  flags_t          flags;
  logic            halted;
  result_t         ex_res;
  result_t         out_res;
  logic            out_valid;

  assign advance  = ex_valid && (!out_valid || m_tready);
  assign s_tready = !ex_valid || advance;
  assign accept   = s_tvalid && s_tready;

  a64ex_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (s_tdata[9:5]),
    .rd_data (rn_data),
    .wr_en   (advance && ex_res.reg_written),
    .wr_addr (ex_res.reg_index),
    .wr_data (ex_res.reg_value)
  );

  a64ex_exec u_exec (
    .instr   (ex_instr),
    .rn_data (rn_data),
    .pc      (pc),
    .flags   (flags),
    .halted  (halted),
    .res     (ex_res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_instr <= s_tdata;
    end
    if (advance) begin
      out_res <= ex_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      flags     <= '0;
      halted    <= 1'b0;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (advance) begin
        ex_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        pc <= cfg_wr_data;
      end else if (advance) begin
        pc <= ex_res.next_pc;
      end
      if (advance) begin
        flags <= ex_res.flags;
        if (ex_res.status == ST_UNHANDLED) begin
          halted <= 1'b1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {6'd0, out_res.reg_value, out_res.reg_index, out_res.reg_written,
                     out_res.flags.v, out_res.flags.c, out_res.flags.z, out_res.flags.n,
                     out_res.next_pc};

endmodule

### design/a64ex_checker.sv
`include "assert_macros.svh"

module a64ex_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [a64ex_pkg::TDATA_W-1:0]  m_tdata,
  input logic [a64ex_pkg::STATUS_W-1:0] m_tuser
);
  import a64ex_pkg::*;

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser != ST_OK) begin
      halt_seen <= 1'b1;
    end
  end

  `A64EX_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result valid right after reset")
  `A64EX_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
                "result changed while stalled")
  `A64EX_ASSERT(a_halt_sticky, m_tvalid && halt_seen |-> m_tuser == ST_HALTED,
                "instruction executed after halt")
  `A64EX_ASSERT(a_no_write_clean, m_tvalid && !m_tdata[68] |-> m_tdata[137:69] == '0,
                "register fields set without a write")
  `A64EX_ASSERT(a_halt_no_write, m_tvalid && m_tuser != ST_OK |-> !m_tdata[68],
                "register written by unexecuted instruction")

endmodule

bind aarch64_addsub_imm_branch_executor a64ex_checker u_a64ex_checker (.*);

### sim/tb_aarch64_addsub_imm_branch_executor.sv
`timescale 1ns / 100ps

module tb_aarch64_addsub_imm_branch_executor;
  import a64ex_pkg::*;

  typedef struct {
    bit              reload;
    logic [XLEN-1:0] load_value;
    logic [ILEN-1:0] word;
    bit              typed;
    result_t         want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [XLEN-1:0]     cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ILEN-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // architectural state as the testbench sees it
  logic [XLEN-1:0] gpr [NREGS];
  logic [XLEN-1:0] arch_pc;
  flags_t          nzcv;
  bit              halted_seen;

  result_t   retire_q [$];
  stim_row_t dir_table [$];
  int        mismatch_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;

  aarch64_addsub_imm_branch_executor i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_aarch64_addsub_imm_branch_executor: done, errors");
    $finish;
  end

  function automatic logic [ILEN-1:0] enc_addsub(input logic sf, input logic sub,
                                                 input logic setf, input logic sh,
                                                 input logic [11:0] imm12,
                                                 input logic [4:0] rn, input logic [4:0] rd);
    return {sf, sub, setf, OP_ADDSUB_IMM, sh, imm12, rn, rd};
  endfunction

  function automatic logic [ILEN-1:0] enc_branch(input logic link, input logic [25:0] imm26);
    return {link, OP_BRANCH, imm26};
  endfunction

  function automatic logic [ILEN-1:0] rand_instruction();
    logic [ILEN-1:0] w;
    w = $urandom;
    if ($urandom_range(99) < 60) w[28:23] = OP_ADDSUB_IMM;
    else w[30:26] = OP_BRANCH;
    return w;
  endfunction

  task automatic exec_instruction(input logic [ILEN-1:0] w, output result_t r);
    logic [XLEN-1:0] mask, imm, a, b, res, off, ret, ovf;
    logic [XLEN:0]   wide;
    int              msb;
    r = '0;
    r.status = ST_OK;
    if (halted_seen) begin
      r.status = ST_HALTED;
    end else if (w[28:23] == OP_ADDSUB_IMM) begin
      mask = w[31] ? '1 : MASK32;
      msb = w[31] ? XLEN - 1 : 31;
      imm = {52'd0, w[21:10]};
      if (w[22]) imm = imm << 12;
      a = gpr[w[9:5]] & mask;
      b = w[30] ? (~imm & mask) : imm;
      wide = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, w[30]};
      res = wide[XLEN-1:0] & mask;
      if (w[29]) begin
        ovf = (a ^ res) & (b ^ res);
        nzcv.n = res[msb];
        nzcv.z = (res == '0);
        nzcv.c = w[31] ? wide[XLEN] : wide[32];
        nzcv.v = ovf[msb];
      end
      arch_pc = arch_pc + PC_STEP;
      // flag-setting form to register 31 is a compare, nothing written
      if (!(w[29] && w[4:0] == REG_SP)) begin
        gpr[w[4:0]] = res;
        r.reg_written = 1'b1;
        r.reg_index = w[4:0];
        r.reg_value = res;
      end
    end else if (w[30:26] == OP_BRANCH) begin
      off = {{36{w[25]}}, w[25:0], 2'b00};
      ret = arch_pc + PC_STEP;
      arch_pc = arch_pc + off;
      if (w[31]) begin
        gpr[REG_LINK] = ret;
        r.reg_written = 1'b1;
        r.reg_index = REG_LINK;
        r.reg_value = ret;
      end
    end else begin
      halted_seen = 1'b1;
      r.status = ST_UNHANDLED;
    end
    r.next_pc = arch_pc;
    r.flags = nzcv;
  endtask

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_retire();
    result_t got, want;
    got.status = m_tuser;
    got.next_pc = m_tdata[63:0];
    got.flags.n = m_tdata[64];
    got.flags.z = m_tdata[65];
    got.flags.c = m_tdata[66];
    got.flags.v = m_tdata[67];
    got.reg_written = m_tdata[68];
    got.reg_index = m_tdata[73:69];
    got.reg_value = m_tdata[137:74];
    if (retire_q.size() == 0) begin
      report_mismatch("unexpected result, next_pc", got.next_pc, '0);
    end else begin
      want = retire_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", XLEN'(got.status), XLEN'(want.status));
      if (got.next_pc !== want.next_pc)
        report_mismatch("next_pc", got.next_pc, want.next_pc);
      if (got.flags.n !== want.flags.n)
        report_mismatch("flag_n", XLEN'(got.flags.n), XLEN'(want.flags.n));
      if (got.flags.z !== want.flags.z)
        report_mismatch("flag_z", XLEN'(got.flags.z), XLEN'(want.flags.z));
      if (got.flags.c !== want.flags.c)
        report_mismatch("flag_c", XLEN'(got.flags.c), XLEN'(want.flags.c));
      if (got.flags.v !== want.flags.v)
        report_mismatch("flag_v", XLEN'(got.flags.v), XLEN'(want.flags.v));
      if (got.reg_written !== want.reg_written)
        report_mismatch("reg_written", XLEN'(got.reg_written), XLEN'(want.reg_written));
      if (got.reg_index !== want.reg_index)
        report_mismatch("reg_index", XLEN'(got.reg_index), XLEN'(want.reg_index));
      if (got.reg_value !== want.reg_value)
        report_mismatch("reg_value", got.reg_value, want.reg_value);
    end
  endtask

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_retire();
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic issue(input logic [ILEN-1:0] w, input bit typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exec_instruction(w, r);
    retire_q.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    while (retire_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_start(input logic [XLEN-1:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    arch_pc = value;
  endtask

  task automatic add_row(input bit reload, input logic [XLEN-1:0] value,
                         input logic [ILEN-1:0] w, input bit typed, input result_t want);
    stim_row_t row;
    row.reload = reload;
    row.load_value = value;
    row.word = w;
    row.typed = typed;
    row.want = want;
    dir_table.push_back(row);
  endtask

  initial begin
    logic [XLEN-1:0] phase_start [4];
    int              phase_idle [4];
    int              phase_stall [4];
    logic [ILEN-1:0] w;

    foreach (gpr[i]) gpr[i] = '0;
    arch_pc = '0;
    nzcv = '0;
    halted_seen = 1'b0;

    // reset state, largest immediates, wraps, writes to the stack pointer
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b0, 1'b0, 12'd0, REG_SP, 5'd0), 1,
            {ST_OK, 64'd4, 4'b0000, 1'b1, 5'd0, 64'd0});
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b0, 1'b0, 12'hFFF, 5'd0, 5'd1), 1,
            {ST_OK, 64'd8, 4'b0000, 1'b1, 5'd1, 64'hFFF});
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b0, 1'b1, 12'hFFF, 5'd1, 5'd2), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b1, 1'b0, 1'b0, 12'd1, REG_SP, 5'd3), 1,
            {ST_OK, 64'd16, 4'b0000, 1'b1, 5'd3, 64'hFFFF_FFFF_FFFF_FFFF});
    add_row(0, '0, enc_addsub(1'b0, 1'b1, 1'b0, 1'b0, 12'd1, REG_SP, 5'd4), 1,
            {ST_OK, 64'd20, 4'b0000, 1'b1, 5'd4, 64'hFFFF_FFFF});
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 5'd3, 5'd5), 0, '0);
    add_row(0, '0, enc_addsub(1'b0, 1'b0, 1'b1, 1'b0, 12'd1, 5'd3, 5'd6), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 5'd0, 5'd7), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b1, 1'b1, 1'b0, 12'hFFF, 5'd1, REG_SP), 0, '0);
    add_row(0, '0, enc_addsub(1'b0, 1'b1, 1'b1, 1'b1, 12'hFFF, 5'd2, REG_SP), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b0, 1'b0, 12'd1, 5'd1, REG_SP), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b0, 1'b0, 12'd0, REG_SP, 5'd9), 0, '0);
    add_row(0, '0, enc_branch(1'b0, 26'd0), 0, '0);
    add_row(0, '0, enc_branch(1'b0, 26'h1FF_FFFF), 0, '0);
    add_row(0, '0, enc_branch(1'b1, 26'h200_0000), 0, '0);
    add_row(1, 64'hFFFF_FFFF_FFFF_FFFC, enc_branch(1'b1, 26'd1), 0, '0);
    // signed overflow, 64-bit then 32-bit
    add_row(1, 64'h7FFF_FFFF_FFFF_FFF8, enc_branch(1'b1, 26'd1), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b0, 1'b1, 1'b0, 12'd4, REG_LINK, 5'd10), 0, '0);
    add_row(0, '0, enc_addsub(1'b1, 1'b1, 1'b1, 1'b0, 12'd1, 5'd10, 5'd11), 0, '0);
    add_row(1, 64'h0000_0000_7FFF_FFF8, enc_branch(1'b1, 26'd1), 0, '0);
    add_row(0, '0, enc_addsub(1'b0, 1'b0, 1'b1, 1'b0, 12'd4, REG_LINK, 5'd12), 0, '0);
    add_row(0, '0, enc_addsub(1'b0, 1'b1, 1'b1, 1'b0, 12'd1, 5'd12, 5'd13), 0, '0);

    phase_start = '{{$urandom, $urandom}, '1, {$urandom, $urandom}, '0};
    phase_idle = '{0, 85, 0, 25};
    phase_stall = '{0, 0, 85, 25};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].reload) load_start(dir_table[i].load_value);
      issue(dir_table[i].word, dir_table[i].typed, dir_table[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      load_start(phase_start[p]);
      src_idle_pct = phase_idle[p];
      sink_stall_pct = phase_stall[p];
      repeat (200) issue(rand_instruction(), 0, '0);
    end

    // an unhandled encoding halts until reset, so it comes last
    do begin
      w = $urandom;
    end while (w[28:23] == OP_ADDSUB_IMM || w[30:26] == OP_BRANCH);
    issue(w, 0, '0);
    repeat (40) issue($urandom, 0, '0);
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && retire_q.size() == 0) begin
      $display("tb_aarch64_addsub_imm_branch_executor: done, clean");
    end else begin
      $display("tb_aarch64_addsub_imm_branch_executor: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/a64ex_pkg.sv
design/a64ex_regfile.sv
design/a64ex_exec.sv
design/aarch64_addsub_imm_branch_executor.sv
design/a64ex_checker.sv
sim/tb_aarch64_addsub_imm_branch_executor.sv
